@@ rtl/sls_pkg.sv @@
// shared types, token codes and classification helpers of the script lexical scanner
package sls_pkg;

	localparam int unsigned MaxSourceBytesDef = 65536;
	localparam int unsigned WordCap = 12;
	localparam int unsigned MaxRes = 4;

	localparam logic [5:0] K_DOT     = 6'd5;
	localparam logic [5:0] K_STRING  = 6'd27;
	localparam logic [5:0] K_NUMBER  = 6'd28;
	localparam logic [5:0] K_IDENT   = 6'd29;
	localparam logic [5:0] K_KW0     = 6'd30;
	localparam logic [5:0] K_END     = 6'd54;
	localparam logic [5:0] K_BADCHAR = 6'd55;
	localparam logic [5:0] K_UNTERM  = 6'd56;

	typedef struct packed {
		logic [7:0] char_in;
		logic       end_of_source;
	} in_item_t;

	typedef struct packed {
		logic [5:0]  token_kind;
		logic [15:0] start_offset;
		logic [16:0] end_offset;
		logic [15:0] line_number;
		logic        last_result;
	} out_item_t;

	// one token without its line number and last flag
	typedef struct packed {
		logic [5:0]  kind;
		logic [16:0] start;
		logic [16:0] stop;
	} tok_t;

	// what the front stage hands to the back stage for one accepted byte
	// tokens below index early were closed before this byte's newline was counted
	typedef struct packed {
		logic [2:0]  count;
		tok_t        t0;
		tok_t        t1;
		tok_t        t2;
		tok_t        t3;
		logic [2:0]  early;
		logic [15:0] line_early;
		logic [15:0] line;
	} batch_t;

	function automatic logic is_dig(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_alp(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic logic [5:0] single_kind(input logic [7:0] p);
		case (p)
			"-": return 6'd6;
			"+": return 6'd9;
			"*": return 6'd11;
			"!": return 6'd17;
			"=": return 6'd19;
			"<": return 6'd22;
			">": return 6'd24;
			default: return 6'd26;
		endcase
	endfunction

	function automatic logic [5:0] pair_kind(input logic [7:0] p, input logic [7:0] c);
		if (p == "-" && c == "=") return 6'd7;
		if (p == "-" && c == ">") return 6'd8;
		if (p == "+" && c == "=") return 6'd10;
		if (p == "*" && c == "*") return 6'd12;
		if (p == "!" && c == "=") return 6'd18;
		if (p == "=" && c == "=") return 6'd20;
		if (p == "=" && c == ">") return 6'd21;
		if (p == "<" && c == "=") return 6'd23;
		if (p == ">" && c == "=") return 6'd25;
		return 6'd0;
	endfunction

	// keyword table, zero padded to the buffer width, first byte in the top bits
	function automatic logic [95:0] kw_text(input int unsigned i);
		case (i)
			0:  return {"and", 72'd0};
			1:  return {"or", 80'd0};
			2:  return {"xor", 72'd0};
			3:  return {"if", 80'd0};
			4:  return {"elif", 64'd0};
			5:  return {"for", 72'd0};
			6:  return {"while", 56'd0};
			7:  return {"def", 72'd0};
			8:  return {"true", 64'd0};
			9:  return {"false", 56'd0};
			10: return {"let", 72'd0};
			11: return {"type", 64'd0};
			12: return {"typeln", 48'd0};
			13: return {"press", 56'd0};
			14: return {"press", "_", "down", 16'd0};
			15: return {"release", 40'd0};
			16: return {"wait", 64'd0};
			17: return {"led", 72'd0};
			18: return {"mode", 64'd0};
			19: return {"vendor", "_", "id", 24'd0};
			20: return {"product", "_", "id", 16'd0};
			21: return {"manufacturer"};
			22: return {"product", 40'd0};
			default: return {"serial", "_", "num", 16'd0};
		endcase
	endfunction

	function automatic logic [3:0] kw_len(input int unsigned i);
		case (i)
			0, 2, 5, 7, 10, 17: return 4'd3;
			1, 3: return 4'd2;
			4, 8, 11, 16, 18: return 4'd4;
			6, 9, 13: return 4'd5;
			12: return 4'd6;
			15, 22: return 4'd7;
			19: return 4'd9;
			14, 20, 23: return 4'd10;
			default: return 4'd12;
		endcase
	endfunction

endpackage

@@ rtl/sls_front.sv @@
// front stage: classifies each byte, tracks scan state and forms the tokens it closes
module sls_front #(
	parameter int unsigned MAX_SOURCE_BYTES = sls_pkg::MaxSourceBytesDef
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  sls_pkg::in_item_t item,
	output sls_pkg::batch_t   batch
);

	localparam logic [16:0] Limit = (MAX_SOURCE_BYTES < 65536) ?
		17'(MAX_SOURCE_BYTES) : 17'd65536;

	typedef enum logic [3:0] {
		M_IDLE, M_OP, M_LINE, M_BLOCK, M_STRING, M_INT, M_DOT, M_FRAC, M_WORD, M_DONE
	} mode_t;

	mode_t       mode_q;
	logic [7:0]  pend_q;
	logic [95:0] word_q;
	logic [4:0]  wlen_q;
	logic [15:0] tstart_q;
	logic [16:0] pos_q;
	logic [15:0] line_q;
	logic        star_q;

	mode_t       mode_d;
	logic [7:0]  pend_d;
	logic [95:0] word_d;
	logic [4:0]  wlen_d;
	logic [15:0] tstart_d;
	logic [16:0] pos_d;
	logic [15:0] line_d;
	logic        star_d;
	logic [5:0]  wkind;

	// parallel keyword compare against the fixed table
	always_comb begin
		wkind = sls_pkg::K_IDENT;
		for (int unsigned i = 0; i < 24; i++) begin
			if (wlen_q == {1'b0, sls_pkg::kw_len(i)} && word_q == sls_pkg::kw_text(i))
				wkind = sls_pkg::K_KW0 + 6'(i);
		end
	end

	function automatic sls_pkg::tok_t mk(input logic [5:0] k, input logic [16:0] s,
		input logic [16:0] e);
		sls_pkg::tok_t t;
		t.kind = k;
		t.start = s;
		t.stop = e;
		return t;
	endfunction

	function automatic logic [15:0] bump(input logic [15:0] l);
		return (l == 16'hFFFF) ? l : l + 16'd1;
	endfunction

	always_comb begin
		sls_pkg::tok_t toks [4];
		logic [2:0] n;
		logic [2:0] early;
		logic [7:0] c;
		logic [16:0] ts;
		logic [16:0] pos1;
		logic go_idle;
		logic fin;
		logic [16:0] fpos;
		toks[0] = '0; toks[1] = '0; toks[2] = '0; toks[3] = '0;
		n = 3'd0;
		early = 3'd0;
		mode_d = mode_q; pend_d = pend_q; word_d = word_q; wlen_d = wlen_q;
		tstart_d = tstart_q; pos_d = pos_q; line_d = line_q; star_d = star_q;
		c = (pos_q >= Limit) ? 8'd0 : item.char_in;
		ts = {1'b0, tstart_q};
		pos1 = pos_q + 17'd1;
		go_idle = 1'b0;
		fin = 1'b0;
		fpos = pos_q;
		if (mode_q != M_DONE) begin
			if (c == 8'd0) begin
				fin = 1'b1;
			end else begin
				pos_d = pos1;
				fin = item.end_of_source;
				fpos = pos1;
				case (mode_q)
					M_OP: begin
						mode_d = M_IDLE;
						if (pend_q == "/" && c == "/") mode_d = M_LINE;
						else if (pend_q == "/" && c == "*") begin
							mode_d = M_BLOCK; star_d = 1'b0;
						end else if (sls_pkg::pair_kind(pend_q, c) != 6'd0) begin
							toks[n[1:0]] = mk(sls_pkg::pair_kind(pend_q, c), ts, pos1);
							n = n + 3'd1;
						end else begin
							toks[n[1:0]] = mk(sls_pkg::single_kind(pend_q), ts, pos_q);
							n = n + 3'd1;
							go_idle = 1'b1;
						end
					end
					M_LINE: if (c == "\n") begin
						line_d = bump(line_q); mode_d = M_IDLE;
					end
					M_BLOCK: begin
						if (star_q && c == "/") begin
							mode_d = M_IDLE; star_d = 1'b0;
						end else begin
							if (c == "\n") line_d = bump(line_q);
							star_d = (c == "*");
						end
					end
					M_STRING: begin
						if (c == "\"") begin
							toks[n[1:0]] = mk(sls_pkg::K_STRING, ts, pos1); n = n + 3'd1;
							mode_d = M_IDLE;
						end else if (c == "\n") line_d = bump(line_q);
					end
					M_INT: begin
						if (c == ".") mode_d = M_DOT;
						else if (!sls_pkg::is_dig(c)) begin
							toks[n[1:0]] = mk(sls_pkg::K_NUMBER, ts, pos_q); n = n + 3'd1;
							mode_d = M_IDLE; go_idle = 1'b1;
						end
					end
					M_DOT: begin
						if (sls_pkg::is_dig(c)) mode_d = M_FRAC;
						else begin
							toks[n[1:0]] = mk(sls_pkg::K_NUMBER, ts, pos_q - 17'd1);
							n = n + 3'd1;
							toks[n[1:0]] = mk(sls_pkg::K_DOT, pos_q - 17'd1, pos_q);
							n = n + 3'd1;
							mode_d = M_IDLE; go_idle = 1'b1;
						end
					end
					M_FRAC: if (!sls_pkg::is_dig(c)) begin
						toks[n[1:0]] = mk(sls_pkg::K_NUMBER, ts, pos_q); n = n + 3'd1;
						mode_d = M_IDLE; go_idle = 1'b1;
					end
					M_WORD: begin
						if (sls_pkg::is_alp(c) || sls_pkg::is_dig(c)) begin
							for (int unsigned i = 0; i < 12; i++)
								if (wlen_q == 5'(i)) word_d[95 - 8*i -: 8] = c;
							if (wlen_q <= 5'd12) wlen_d = wlen_q + 5'd1;
						end else begin
							toks[n[1:0]] = mk(wkind, ts, pos_q); n = n + 3'd1;
							mode_d = M_IDLE; go_idle = 1'b1;
						end
					end
					default: go_idle = 1'b1;
				endcase
				if (go_idle) begin
					tstart_d = pos_q[15:0];
					case (c)
						"(", ")", "{", "}", ",", ".", "&", "|", "^", "%": begin
							case (c)
								"(": toks[n[1:0]] = mk(6'd0, pos_q, pos1);
								")": toks[n[1:0]] = mk(6'd1, pos_q, pos1);
								"{": toks[n[1:0]] = mk(6'd2, pos_q, pos1);
								"}": toks[n[1:0]] = mk(6'd3, pos_q, pos1);
								",": toks[n[1:0]] = mk(6'd4, pos_q, pos1);
								".": toks[n[1:0]] = mk(sls_pkg::K_DOT, pos_q, pos1);
								"&": toks[n[1:0]] = mk(6'd13, pos_q, pos1);
								"|": toks[n[1:0]] = mk(6'd14, pos_q, pos1);
								"^": toks[n[1:0]] = mk(6'd15, pos_q, pos1);
								default: toks[n[1:0]] = mk(6'd16, pos_q, pos1);
							endcase
							n = n + 3'd1;
						end
						"-", "+", "*", "!", "=", "<", ">", "/": begin
							pend_d = c; mode_d = M_OP;
						end
						" ", "\r", "\t": ;
						"\n": line_d = bump(line_q);
						"\"": mode_d = M_STRING;
						default: begin
							if (sls_pkg::is_dig(c)) mode_d = M_INT;
							else if (sls_pkg::is_alp(c)) begin
								word_d = {c, 88'd0}; wlen_d = 5'd1; mode_d = M_WORD;
							end else begin
								toks[n[1:0]] = mk(sls_pkg::K_BADCHAR, pos_q, pos1);
								n = n + 3'd1;
							end
						end
					endcase
				end
			end
			// tokens so far were closed before any newline of this byte
			early = n;
			if (fin) begin
				// close the pending token, then the end token
				case (mode_d)
					M_OP: begin
						toks[n[1:0]] = mk(sls_pkg::single_kind(pend_d), {1'b0, tstart_d}, fpos);
						n = n + 3'd1;
					end
					M_STRING: begin
						toks[n[1:0]] = mk(sls_pkg::K_UNTERM, {1'b0, tstart_d}, fpos);
						n = n + 3'd1;
					end
					M_INT, M_FRAC: begin
						toks[n[1:0]] = mk(sls_pkg::K_NUMBER, {1'b0, tstart_d}, fpos);
						n = n + 3'd1;
					end
					M_DOT: begin
						toks[n[1:0]] = mk(sls_pkg::K_NUMBER, {1'b0, tstart_d}, fpos - 17'd1);
						n = n + 3'd1;
						toks[n[1:0]] = mk(sls_pkg::K_DOT, fpos - 17'd1, fpos);
						n = n + 3'd1;
					end
					M_WORD: begin
						// word kind from the buffer after this byte's update
						toks[n[1:0]] = mk(sls_pkg::K_IDENT, {1'b0, tstart_d}, fpos);
						for (int unsigned i = 0; i < 24; i++)
							if (wlen_d == {1'b0, sls_pkg::kw_len(i)} &&
								word_d == sls_pkg::kw_text(i))
								toks[n[1:0]].kind = sls_pkg::K_KW0 + 6'(i);
						n = n + 3'd1;
					end
					default: ;
				endcase
				if (n < 3'd4) begin
					toks[n[1:0]] = mk(sls_pkg::K_END, 17'd0, fpos); n = n + 3'd1;
				end
				mode_d = M_DONE;
			end
		end
		batch.count = n;
		batch.t0 = toks[0]; batch.t1 = toks[1]; batch.t2 = toks[2]; batch.t3 = toks[3];
		batch.early = early;
		batch.line_early = line_q;
		batch.line = line_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE; pend_q <= '0; wlen_q <= '0; tstart_q <= '0;
			pos_q <= '0; line_q <= 16'd1; star_q <= 1'b0;
		end else if (take) begin
			mode_q <= mode_d; pend_q <= pend_d; wlen_q <= wlen_d; tstart_q <= tstart_d;
			pos_q <= pos_d; line_q <= line_d; star_q <= star_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take) word_q <= word_d;
	end

endmodule

@@ rtl/sls_back.sv @@
// back stage: batch queue and serializer that sends one token per transfer
module sls_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  sls_pkg::batch_t     batch,
	output logic                room,
	output logic                out_valid,
	input  logic                out_ready,
	output sls_pkg::out_item_t  out_item
);

	sls_pkg::batch_t q_q [2];
	logic            wp_q, rp_q;
	logic [1:0]      cnt_q;
	logic [1:0]      idx_q;
	sls_pkg::tok_t   cur;
	sls_pkg::batch_t head;
	logic            pop_tok, pop_batch, do_push;

	assign head = q_q[rp_q];
	// empty batches carry no tokens and are never stored
	assign do_push = push && batch.count != 3'd0;
	assign room = cnt_q != 2'd2;
	assign out_valid = cnt_q != 2'd0;
	always_comb begin
		case (idx_q)
			2'd0: cur = head.t0;
			2'd1: cur = head.t1;
			2'd2: cur = head.t2;
			default: cur = head.t3;
		endcase
	end
	assign pop_tok = out_valid && out_ready;
	assign pop_batch = pop_tok && ({1'b0, idx_q} + 3'd1 == head.count);
	assign out_item.token_kind = cur.kind;
	assign out_item.start_offset = cur.start[15:0];
	assign out_item.end_offset = cur.stop;
	// tokens closed ahead of a newline keep the line they were on
	assign out_item.line_number = ({1'b0, idx_q} < head.early) ? head.line_early : head.line;
	assign out_item.last_result = ({1'b0, idx_q} + 3'd1 == head.count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0; idx_q <= '0;
		end else begin
			if (do_push) wp_q <= ~wp_q;
			if (pop_batch) begin rp_q <= ~rp_q; idx_q <= '0; end
			else if (pop_tok) idx_q <= idx_q + 2'd1;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, pop_batch};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) q_q[wp_q] <= batch;
	end

endmodule

@@ rtl/script_lexical_scanner.sv @@
// top level of the script lexical scanner
// Takes one source byte per transfer and returns tokens in source order, one token per
// output transfer, with last_result marking the final token a byte caused. A byte is taken
// in the cycle it arrives whenever the two-entry batch queue between the classifier and the
// token serializer has room; while out_ready stays high the sustained rate is one byte per
// cycle for bytes causing at most one token. Keywords are matched in the same cycle against
// a fixed table. No clearing pass follows reset.
module script_lexical_scanner #(
	parameter int unsigned MAX_SOURCE_BYTES = sls_pkg::MaxSourceBytesDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  sls_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output sls_pkg::out_item_t out_data
);

	sls_pkg::batch_t batch;
	logic            take;

	// an input transfer updates scan state and queues its tokens together
	assign take = in_valid && in_ready;

	sls_front #(.MAX_SOURCE_BYTES(MAX_SOURCE_BYTES)) u_front (
		.clk(clk), .arst_n(arst_n), .take(take), .item(in_data), .batch(batch)
	);

	sls_back u_back (
		.clk(clk), .arst_n(arst_n), .push(take), .batch(batch), .room(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_data)
	);

endmodule

@@ rtl/sls_checker.sv @@
// port-level checker of the script lexical scanner and its bind
module sls_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input sls_pkg::out_item_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output changed while stalled");

	a_line_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.line_number != 16'd0)
		else $error("line number zero");

	a_end_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.token_kind == sls_pkg::K_END |->
		out_data.start_offset == 16'd0 && out_data.last_result)
		else $error("end token malformed");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.token_kind != sls_pkg::K_END &&
		out_data.token_kind != sls_pkg::K_DOT |->
		{1'b0, out_data.start_offset} < out_data.end_offset)
		else $error("token span empty");

	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with nothing queued");

endmodule

bind script_lexical_scanner sls_checker u_sls_checker (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
